// ----- src/ffpa_pkg.sv -----
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared types and constants for the first-fit page allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

  localparam int PAGE_BYTES   = 64;
  localparam int PAGE_COUNT   = 16;
  localparam int MEMORY_BYTES = 1024;

  localparam int HANDLE_W = 16;
  localparam int BYTES_W  = 16;
  localparam int STAT_W   = 11;

  // page index and page count widths
  localparam int IDX_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int CNT_W = $clog2(PAGE_COUNT + 1);

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD       = 3'd1;
  localparam logic [2:0] ST_NO_ROOM   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EXHAUSTED = 3'd4;

  typedef struct packed {
    logic                action;
    logic [BYTES_W-1:0]  request_bytes;
    logic [HANDLE_W-1:0] owner_handle;
  } req_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [HANDLE_W-1:0] granted_handle;
    logic [STAT_W-1:0]   free_bytes;
    logic [STAT_W-1:0]   largest_free_bytes;
    logic [STAT_W-1:0]   smallest_free_bytes;
  } rsp_t;

endpackage

// ----- src/first_fit_page_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_page_allocator
// Page owner table with first-fit allocate, free by handle, free-space stats.
// ----------------------------------------------------------------------------
// Usage: requests arrive on in_valid/in_ready/in_item (allocate a byte count
// or free every page of a handle); each request yields exactly one response
// on out_valid/out_ready/out_item with a status, the granted handle and the
// free, largest-run and smallest-run byte counts after the operation.
// One request is worked at a time by a sequencer that walks the page table
// one entry per cycle through a single compare/count unit:
//   accept
//   allocate search             stops at first fit
//   mark pages                  each granted page in turn
//   free scan                   every page of the table
//   statistics pass             every page, then closes the last run
// A request that fails its early checks goes straight to the statistics pass.
// in_ready is high only while idle. The response sits in an output register,
// so the next request may be accepted while it waits; if the receiver still
// stalls when the next statistics pass ends, the sequencer holds there.
// Reset (rst, synchronous) marks all pages free and sets the next handle to 1.
// ----------------------------------------------------------------------------
module first_fit_page_allocator
  import ffpa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_item,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_item
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_MARK,
    S_CLEAR,
    S_STATS
  } state_t;

  state_t state;

  logic [HANDLE_W-1:0] page_owner [PAGE_COUNT];
  logic [HANDLE_W:0]   next_handle;
  logic [CNT_W-1:0]    idx;
  logic [CNT_W-1:0]    run;
  logic [CNT_W-1:0]    need;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    maxr;
  logic [CNT_W-1:0]    minr;
  logic                found;
  logic [HANDLE_W-1:0] handle;
  logic [2:0]          status;
  logic [HANDLE_W-1:0] granted;

  logic [HANDLE_W-1:0] page_rd;
  logic                page_free;
  logic                in_range;
  logic                last_page;
  logic                last_stats;
  logic [CNT_W-1:0]    run_inc;
  logic [BYTES_W:0]    bytes_up;
  logic [BYTES_W:0]    need_full;
  logic                st_free;
  logic [CNT_W-1:0]    count_next;
  logic [CNT_W-1:0]    maxr_next;
  logic [CNT_W-1:0]    minr_next;
  logic                out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    page_rd    = page_owner[idx[IDX_W-1:0]];
    page_free  = (page_rd == '0);
    in_range   = (idx < CNT_W'(PAGE_COUNT));
    last_page  = (idx == CNT_W'(PAGE_COUNT - 1));
    last_stats = (idx == CNT_W'(PAGE_COUNT));
    run_inc    = run + CNT_W'(1);
    bytes_up   = {1'b0, in_item.request_bytes} + (BYTES_W + 1)'(PAGE_BYTES - 1);
    need_full  = (BYTES_W + 1)'(bytes_up / PAGE_BYTES);

    // one step of the statistics walk; the step past the end closes the run
    st_free    = in_range && page_free;
    count_next = st_free ? count + CNT_W'(1) : count;
    maxr_next  = maxr;
    minr_next  = minr;
    if (!st_free && run != '0) begin
      if (run > maxr) begin
        maxr_next = run;
      end
      if (minr == '0 || run < minr) begin
        minr_next = run;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      next_handle <= (HANDLE_W + 1)'(1);
      for (int i = 0; i < PAGE_COUNT; i++) begin
        page_owner[i] <= '0;
      end
    end else begin
      if (state == S_STATS && last_stats && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            idx     <= '0;
            run     <= '0;
            count   <= '0;
            maxr    <= '0;
            minr    <= '0;
            found   <= 1'b0;
            granted <= '0;
            status  <= ST_OK;
            handle  <= in_item.owner_handle;
            if (in_item.action == ACT_ALLOC) begin
              priority if (in_item.request_bytes == '0) begin
                status <= ST_BAD;
                state  <= S_STATS;
              end else if (next_handle[HANDLE_W]) begin
                status <= ST_EXHAUSTED;
                state  <= S_STATS;
              end else if (need_full > (BYTES_W + 1)'(PAGE_COUNT)) begin
                status <= ST_NO_ROOM;
                state  <= S_STATS;
              end else begin
                need  <= need_full[CNT_W-1:0];
                state <= S_SEARCH;
              end
            end else begin
              if (in_item.owner_handle == '0) begin
                status <= ST_BAD;
                state  <= S_STATS;
              end else begin
                state <= S_CLEAR;
              end
            end
          end
        end

        S_SEARCH: begin
          if (page_free && run_inc == need) begin
            // first fit: run ends here, jump back to its first page
            idx   <= idx + CNT_W'(1) - need;
            run   <= '0;
            state <= S_MARK;
          end else if (last_page) begin
            status <= ST_NO_ROOM;
            idx    <= '0;
            run    <= '0;
            state  <= S_STATS;
          end else begin
            run <= page_free ? run_inc : '0;
            idx <= idx + CNT_W'(1);
          end
        end

        S_MARK: begin
          page_owner[idx[IDX_W-1:0]] <= next_handle[HANDLE_W-1:0];
          need <= need - CNT_W'(1);
          if (need == CNT_W'(1)) begin
            granted     <= next_handle[HANDLE_W-1:0];
            next_handle <= next_handle + (HANDLE_W + 1)'(1);
            idx         <= '0;
            state       <= S_STATS;
          end else begin
            idx <= idx + CNT_W'(1);
          end
        end

        S_CLEAR: begin
          if (page_rd == handle) begin
            page_owner[idx[IDX_W-1:0]] <= '0;
            found <= 1'b1;
          end
          if (last_page) begin
            status <= (found || page_rd == handle) ? ST_OK : ST_NOT_FOUND;
            idx    <= '0;
            state  <= S_STATS;
          end else begin
            idx <= idx + CNT_W'(1);
          end
        end

        S_STATS: begin
          if (!last_stats) begin
            count <= count_next;
            maxr  <= maxr_next;
            minr  <= minr_next;
            run   <= st_free ? run_inc : '0;
            idx   <= idx + CNT_W'(1);
          end else if (out_free) begin
            out_item.status              <= status;
            out_item.granted_handle      <= granted;
            out_item.free_bytes          <= STAT_W'(count_next * PAGE_BYTES);
            out_item.largest_free_bytes  <= STAT_W'(maxr_next * PAGE_BYTES);
            out_item.smallest_free_bytes <= STAT_W'(minr_next * PAGE_BYTES);
            state                        <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
